// ----- hw/rtl/jsfe_pkg.sv -----
// Shared types and constants for the JSON string field extractor.
`timescale 1ns / 1ps

package jsfe_pkg;

   localparam int MaxKeyBytesDefault = 16;

   // configuration register indexes
   localparam logic [1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [1:0] CSR_KEY_HIGH = 2'd1;
   localparam logic [1:0] CSR_KEY_LEN  = 2'd2;

   // parse phases
   localparam logic [2:0] PH_SEARCH = 3'd0;
   localparam logic [2:0] PH_COLON  = 3'd1;
   localparam logic [2:0] PH_QUOTE  = 3'd2;
   localparam logic [2:0] PH_VALUE  = 3'd3;
   localparam logic [2:0] PH_ESCAPE = 3'd4;
   localparam logic [2:0] PH_DONE   = 3'd5;

   // result status codes
   localparam logic [1:0] ST_BYTE     = 2'd0;
   localparam logic [1:0] ST_COMPLETE = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;

   // characters
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_TAB       = 8'h09;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] value_byte;
      logic [1:0] status;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } win_ctl_type;

   function automatic logic [7:0] decode_escape(input logic [7:0] e);
      logic [7:0] d;
      case (e)
         CH_N:    d = CH_LF;
         CH_R:    d = CH_CR;
         CH_T:    d = CH_TAB;
         default: d = e; // quote, backslash, slash and the rest pass as themselves
      endcase
      return d;
   endfunction

endpackage

// ----- hw/rtl/jsfe_window.sv -----
// Sliding byte window and parallel quoted-key compare.
`timescale 1ns / 1ps

module jsfe_window #(
   parameter int MAX_KEY_BYTES = jsfe_pkg::MaxKeyBytesDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  jsfe_pkg::win_ctl_type win_ctl,
   input  logic [7:0]            text_byte,
   input  logic [127:0]          key_bytes,
   input  logic [4:0]            key_length,
   output logic                  match
);

   localparam int WinDepth = MAX_KEY_BYTES + 2;
   localparam int SeenW    = $clog2(WinDepth + 1);
   localparam int LenW     = $clog2(MAX_KEY_BYTES + 1);

   logic [7:0]             win_ff [WinDepth];
   logic [7:0]             win_in [WinDepth];
   logic [SeenW-1:0]       seen_ff;
   logic [SeenW-1:0]       seen_in;
   logic [MAX_KEY_BYTES:0] match_by_len;
   logic [LenW-1:0]        len_sel;

   // window as it stands once the current byte has been shifted in
   always_comb begin
      win_in[0] = text_byte;
      for (int k = 1; k < WinDepth; k++) begin
         win_in[k] = win_ff[k-1];
      end
      seen_in = (seen_ff == SeenW'(WinDepth)) ? seen_ff : seen_ff + 1'b1;
   end

   // one comparator row per possible key length
   always_comb begin
      for (int l = 0; l <= MAX_KEY_BYTES; l++) begin
         match_by_len[l] = (int'(seen_in) >= l + 2) && (win_in[l+1] == jsfe_pkg::CH_QUOTE)
                           && (win_in[0] == jsfe_pkg::CH_QUOTE);
         for (int j = 0; j < l; j++) begin
            if (win_in[l-j] != key_bytes[8*j +: 8]) begin
               match_by_len[l] = 1'b0;
            end
         end
      end
   end

   assign len_sel = (key_length > 5'(MAX_KEY_BYTES)) ? LenW'(MAX_KEY_BYTES)
                                                     : LenW'(key_length);
   assign match   = match_by_len[len_sel];

   always_ff @(posedge clock) begin
      if (reset || win_ctl.clear) begin
         for (int k = 0; k < WinDepth; k++) begin
            win_ff[k] <= 8'd0;
         end
         seen_ff <= '0;
      end else if (win_ctl.shift) begin
         win_ff  <= win_in;
         seen_ff <= seen_in;
      end
   end

endmodule

// ----- hw/rtl/jsfe_core.sv -----
// Parse phase sequencer, escape decode and result register.
`timescale 1ns / 1ps

module jsfe_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  jsfe_pkg::req_type     item,
   input  logic                  match,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output jsfe_pkg::rsp_type     rsp_payload,
   output logic                  advance,
   output jsfe_pkg::win_ctl_type win_ctl
);

   logic [2:0]        phase_ff;
   logic [2:0]        phase_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   jsfe_pkg::rsp_type rsp_ff;
   jsfe_pkg::rsp_type res;
   logic              has_res;
   logic              shift;

   always_comb begin
      phase_in = phase_ff;
      has_res  = 1'b0;
      res      = '{value_byte: 8'd0, status: jsfe_pkg::ST_NOTFOUND, last_of_run: 1'b1};
      shift    = 1'b0;
      unique case (phase_ff)
         jsfe_pkg::PH_SEARCH: begin
            shift = 1'b1;
            if (item.end_of_text) begin
               has_res = 1'b1;
            end else if (match) begin
               phase_in = jsfe_pkg::PH_COLON;
            end
         end
         jsfe_pkg::PH_COLON: begin
            if (item.end_of_text) begin
               has_res = 1'b1;
            end else if (item.text_byte == jsfe_pkg::CH_COLON) begin
               phase_in = jsfe_pkg::PH_QUOTE;
            end
         end
         jsfe_pkg::PH_QUOTE: begin
            if (item.end_of_text) begin
               has_res = 1'b1;
            end else if (item.text_byte == jsfe_pkg::CH_QUOTE) begin
               phase_in = jsfe_pkg::PH_VALUE;
            end
         end
         jsfe_pkg::PH_VALUE: begin
            // closing quote wins over end of text
            if (item.text_byte == jsfe_pkg::CH_QUOTE) begin
               has_res    = 1'b1;
               res.status = jsfe_pkg::ST_COMPLETE;
               phase_in   = jsfe_pkg::PH_DONE;
            end else if (item.end_of_text) begin
               has_res = 1'b1;
            end else if (item.text_byte == jsfe_pkg::CH_BACKSLASH) begin
               phase_in = jsfe_pkg::PH_ESCAPE;
            end else begin
               has_res = 1'b1;
               res     = '{value_byte: item.text_byte, status: jsfe_pkg::ST_BYTE,
                           last_of_run: 1'b0};
            end
         end
         jsfe_pkg::PH_ESCAPE: begin
            has_res = 1'b1;
            if (!item.end_of_text) begin
               res      = '{value_byte: jsfe_pkg::decode_escape(item.text_byte),
                            status: jsfe_pkg::ST_BYTE, last_of_run: 1'b0};
               phase_in = jsfe_pkg::PH_VALUE;
            end
         end
         default: begin
            // done, and unused codes: drop bytes quietly
         end
      endcase
      if (item.end_of_text) begin
         phase_in = jsfe_pkg::PH_SEARCH;
      end
   end

   // a request leaves the input stage when it gives no result or its result has somewhere to go
   assign advance = item_valid && (!has_res || !rsp_valid_ff || !rsp_stall);

   assign win_ctl.shift = advance && shift;
   assign win_ctl.clear = advance && item.end_of_text;

   always_comb begin
      if (advance && has_res) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= jsfe_pkg::PH_SEARCH;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_res) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- hw/rtl/json_string_field_extractor_top.sv -----
// Top level of the JSON string field extractor.
//
// req_ channel: one JSON text byte per request, with end_of_text on the
// final byte of a document. rsp_ channel: decoded value bytes (status 0),
// then a completion (status 1) or not-found (status 2) marked last_of_run.
// Most requests give no response. csr_ channel: index 0 and 1 load the key
// bytes, index 2 the key length; csr_ready is always high. Write it only
// while no request is in flight.
// Throughput: one request per cycle unless a stalled response holds it back;
// the window compare and phase update are combinational between the input
// register and the response register, from which each response is shown.
// A stalled response holds in its register; the request behind it is held
// in the input register only when it too produces a response, and req_stall
// then rises. Reset (synchronous) empties both registers, clears the window
// and keys, and returns the parser to key search.
`timescale 1ns / 1ps

module json_string_field_extractor_top #(
   parameter int MAX_KEY_BYTES = jsfe_pkg::MaxKeyBytesDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  jsfe_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output jsfe_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [63:0]       csr_wdata
);

   logic                  item_valid_ff;
   logic                  item_valid_in;
   jsfe_pkg::req_type     item_ff;
   logic                  req_accept;
   logic                  advance;
   logic                  match;
   jsfe_pkg::win_ctl_type win_ctl;
   logic [63:0]           key_low_ff;
   logic [63:0]           key_high_ff;
   logic [4:0]            key_len_ff;

   assign csr_ready  = 1'b1;
   assign req_stall  = item_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= 64'd0;
         key_high_ff <= 64'd0;
         key_len_ff  <= 5'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            jsfe_pkg::CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            jsfe_pkg::CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            jsfe_pkg::CSR_KEY_LEN:  key_len_ff  <= csr_wdata[4:0];
            default: begin
               // no register at this index
            end
         endcase
      end
   end

   jsfe_window #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .win_ctl    (win_ctl),
      .text_byte  (item_ff.text_byte),
      .key_bytes  ({key_high_ff, key_low_ff}),
      .key_length (key_len_ff),
      .match      (match)
   );

   jsfe_core u_core (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid_ff),
      .item        (item_ff),
      .match       (match),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .advance     (advance),
      .win_ctl     (win_ctl)
   );

`ifndef NO_ASSERTIONS
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request held without a stalled response");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != jsfe_pkg::ST_BYTE) |-> rsp_payload.value_byte == 8'd0)
      else $error("value byte not zero on a final response");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.last_of_run == (rsp_payload.status != jsfe_pkg::ST_BYTE)))
      else $error("last_of_run disagrees with status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == jsfe_pkg::ST_BYTE
                     || rsp_payload.status == jsfe_pkg::ST_COMPLETE
                     || rsp_payload.status == jsfe_pkg::ST_NOTFOUND))
      else $error("undefined status code");
`endif

endmodule
